// File: hw/rtl/dam_pkg.sv
// shared types, codes and constants for the decimal accumulator machine
package dam_pkg;

  // default configuration
  localparam int unsigned MemDepthDefault = 512;
  localparam int unsigned WordBitsDefault = 32;

  // stream payload layout
  localparam int unsigned OpcodeW   = 2;
  localparam int unsigned AddrW     = 9;
  localparam int unsigned FieldW    = 32;
  localparam int unsigned InDataW   = 80;
  localparam int unsigned InUserW   = 2;
  localparam int unsigned OutDataW  = 48;
  localparam int unsigned OutUserW  = 1;
  localparam int unsigned OpcW      = 4;
  localparam int unsigned RemW      = 14;
  localparam int unsigned OperandW  = 10;

  // decimal instruction encoding
  localparam logic [RemW-1:0] DecBase  = RemW'(1000);
  localparam logic [RemW-1:0] DecLimit = RemW'(10000);

  // item kinds carried in s_axis_tuser
  typedef enum logic [OpcodeW-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_EXEC  = 2'd1,
    KIND_SETPC = 2'd2,
    KIND_NONE  = 2'd3
  } item_kind_e;

  // instruction operation codes
  localparam logic [OpcW-1:0] OP_GET  = 4'd1;
  localparam logic [OpcW-1:0] OP_PUT  = 4'd2;
  localparam logic [OpcW-1:0] OP_LD   = 4'd3;
  localparam logic [OpcW-1:0] OP_ST   = 4'd4;
  localparam logic [OpcW-1:0] OP_ADD  = 4'd5;
  localparam logic [OpcW-1:0] OP_SUB  = 4'd6;
  localparam logic [OpcW-1:0] OP_JPOS = 4'd7;
  localparam logic [OpcW-1:0] OP_JZ   = 4'd8;
  localparam logic [OpcW-1:0] OP_J    = 4'd9;

  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_DECODE = 3'd2,
    ST_DIV    = 3'd3,
    ST_EXEC   = 3'd4,
    ST_OPER   = 3'd5,
    ST_RESP   = 3'd6
  } state_e;

endpackage

// File: hw/rtl/decimal_accumulator_machine.sv
// decimal accumulator machine: top level with sequencer and datapath
// sequence: load, set-pc, unknown, halted and bad-fetch items answer in the cycle after accept,
//   a negative or >= 10000 word after decode; other steps go decode, divide (op = word / 1000),
//   exec, plus operand for load/add/subtract: divide takes 1000 off per cycle on the shared alu
// throughput: one item in flight; next accept after the result transaction
// reset: async active low, then a clearing pass over all MEM_DEPTH words with s_axis_tready low
module decimal_accumulator_machine
  import dam_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = MemDepthDefault,
  parameter int unsigned WORD_BITS = WordBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // load_addr[8:0], load_word[40:9], get_value[72:41], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // put_value[31:0], next_pc[40:32], halted[41], fault[42], zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  // put_valid[0]
  output logic [OutUserW-1:0] m_axis_tuser
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam logic [OperandW-1:0] Depth = OperandW'(MEM_DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(MEM_DEPTH - 1);
  localparam logic [OperandW-1:0] PcSpan = OperandW'(511);

  // input fields
  item_kind_e               in_kind;
  logic [AddrW-1:0]         in_addr;
  logic signed [FieldW-1:0] in_word;
  logic signed [FieldW-1:0] in_get;

  assign in_kind = item_kind_e'(s_axis_tuser);
  assign in_addr = s_axis_tdata[8:0];
  assign in_word = s_axis_tdata[40:9];
  assign in_get  = s_axis_tdata[72:41];

  // state
  state_e               state_q, state_d;
  logic [AW-1:0]        clr_cnt_q;
  logic [AddrW-1:0]     pc_q;
  logic [WORD_BITS-1:0] acc_q;
  logic                 halt_q, fault_q;
  logic [WORD_BITS-1:0] get_q;
  logic [RemW-1:0]      rem_q;
  logic [OpcW-1:0]      opc_q;
  logic                 put_valid_q;
  logic [FieldW-1:0]    put_value_q;

  // memory and alu hookups
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
  alu_op_e              alu_op;
  logic [WORD_BITS-1:0] alu_a, alu_b, alu_res;
  logic                 alu_borrow;

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // decode of the instruction being executed
  logic [OperandW-1:0] operand;
  logic                acc_pos, acc_zero, take, needs_addr, addr_ok, op_valid;
  logic                pc_ok, word_neg, word_big;

  assign operand  = rem_q[OperandW-1:0];
  assign acc_zero = (acc_q == '0);
  assign acc_pos  = !acc_zero && !acc_q[WORD_BITS-1];
  assign take     = (opc_q == OP_J) || ((opc_q == OP_JPOS) && acc_pos)
                    || ((opc_q == OP_JZ) && acc_zero);
  assign op_valid = (opc_q != '0) && (opc_q <= OP_J);
  assign needs_addr = ((opc_q >= OP_LD) && (opc_q <= OP_SUB))
                      || ((opc_q >= OP_JPOS) && take);
  assign addr_ok  = (operand < Depth) && (operand <= PcSpan);
  assign pc_ok    = ({1'b0, pc_q} < Depth);
  assign word_neg = mem_rdata[WORD_BITS-1];
  assign word_big = (mem_rdata >= WORD_BITS'(DecLimit));

  dam_mem #(
    .MEM_DEPTH(MEM_DEPTH),
    .WORD_BITS(WORD_BITS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  dam_alu #(
    .WORD_BITS(WORD_BITS)
  ) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .borrow_o(alu_borrow)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == LastIdx) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_EXEC && !halt_q && pc_ok) state_d = ST_DECODE;
          else state_d = ST_RESP;
        end
      end
      ST_DECODE: begin
        if (word_neg || word_big) state_d = ST_RESP;
        else state_d = ST_DIV;
      end
      ST_DIV: begin
        // quotient done once another 1000 no longer fits
        if (alu_borrow) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (!op_valid || (needs_addr && !addr_ok)) state_d = ST_RESP;
        else if (opc_q == OP_LD || opc_q == OP_ADD || opc_q == OP_SUB) state_d = ST_OPER;
        else state_d = ST_RESP;
      end
      ST_OPER: state_d = ST_RESP;
      ST_RESP: begin
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = clr_cnt_q;
    mem_wdata     = '0;
    mem_raddr     = AW'(pc_q);
    alu_op        = ALU_SUB;
    alu_a         = WORD_BITS'(rem_q);
    alu_b         = WORD_BITS'(DecBase);
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mem_waddr     = AW'(in_addr);
        mem_wdata     = WORD_BITS'(in_word);
        mem_we        = accept && (in_kind == KIND_LOAD) && ({1'b0, in_addr} < Depth);
      end
      ST_EXEC: begin
        mem_raddr = AW'(operand);
        mem_waddr = AW'(operand);
        mem_wdata = acc_q;
        mem_we    = op_valid && addr_ok && (opc_q == OP_ST);
      end
      ST_OPER: begin
        alu_op = (opc_q == OP_ADD) ? ALU_ADD : ALU_SUB;
        alu_a  = acc_q;
        alu_b  = mem_rdata;
      end
      ST_RESP: m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      pc_q      <= '0;
      acc_q     <= '0;
      halt_q    <= 1'b0;
      fault_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_CLEAR: clr_cnt_q <= clr_cnt_q + AW'(1);
        ST_IDLE: begin
          if (accept && in_kind == KIND_SETPC) begin
            pc_q    <= in_addr;
            halt_q  <= 1'b0;
            fault_q <= 1'b0;
          end else if (accept && in_kind == KIND_EXEC && !halt_q && !pc_ok) begin
            // fetch address beyond the memory
            halt_q  <= 1'b1;
            fault_q <= 1'b1;
          end
        end
        ST_DECODE: begin
          if (word_neg || word_big) halt_q <= 1'b1;
        end
        ST_EXEC: begin
          if (!op_valid) begin
            halt_q <= 1'b1;
          end else if (needs_addr && !addr_ok) begin
            halt_q  <= 1'b1;
            fault_q <= 1'b1;
          end else begin
            if (opc_q >= OP_JPOS && take) pc_q <= operand[AddrW-1:0];
            else pc_q <= pc_q + AddrW'(1);
            if (opc_q == OP_GET) acc_q <= get_q;
          end
        end
        ST_OPER: begin
          if (opc_q == OP_LD) acc_q <= mem_rdata;
          else acc_q <= alu_res;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          get_q       <= WORD_BITS'(in_get);
          put_valid_q <= 1'b0;
          put_value_q <= '0;
        end
      end
      ST_DECODE: begin
        rem_q <= mem_rdata[RemW-1:0];
        opc_q <= '0;
      end
      ST_DIV: begin
        if (!alu_borrow) begin
          rem_q <= alu_res[RemW-1:0];
          opc_q <= opc_q + OpcW'(1);
        end
      end
      ST_EXEC: begin
        if (op_valid && opc_q == OP_PUT) begin
          put_valid_q <= 1'b1;
          put_value_q <= FieldW'(acc_q);
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {5'd0, fault_q, halt_q, pc_q, put_value_q};
  assign m_axis_tuser = put_valid_q;

endmodule

// File: hw/rtl/dam_alu.sv
// shared add/subtract unit with borrow out
module dam_alu
  import dam_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDefault
) (
  input  alu_op_e              op_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  output logic [WORD_BITS-1:0] res_o,
  output logic                 borrow_o
);

  logic [WORD_BITS:0] sum;

  always_comb begin
    unique case (op_i)
      ALU_ADD: sum = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: sum = {1'b0, a_i} - {1'b0, b_i};
      default: sum = '0;
    endcase
  end

  assign res_o    = sum[WORD_BITS-1:0];
  // only meaningful for subtraction: set when b > a
  assign borrow_o = (op_i == ALU_SUB) && sum[WORD_BITS];

endmodule

// File: hw/rtl/dam_mem.sv
// single-port-write, single-port-read word memory with registered read data
module dam_mem
  import dam_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = MemDepthDefault,
  parameter int unsigned WORD_BITS = WordBitsDefault,
  localparam int unsigned AW = $clog2(MEM_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hw/rtl/dam_checker.sv
// port-level checks for the decimal accumulator machine, bound to the top level
module dam_checker
  import dam_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [OutUserW-1:0] m_axis_tuser
);

  // result held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item at a time: never ready while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  // accepted item closes the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after accept");

  // a fault always comes with a halt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[42] |-> m_axis_tdata[41])
    else $error("fault without halt");

  // a put never reports a halted machine
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[41])
    else $error("put reported while halted");

endmodule

bind decimal_accumulator_machine dam_checker u_dam_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
